// ===== sv/glb2_pkg.sv =====
package glb2_pkg;

	// input command codes
	localparam logic [1:0] CMD_STRING = 2'd0;
	localparam logic [1:0] CMD_CHAR   = 2'd1;
	localparam logic [1:0] CMD_BYTE   = 2'd2;

	// string phase codes
	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_ACTIVE  = 2'd1;
	localparam logic [1:0] PH_GLYPH   = 2'd2;
	localparam logic [1:0] PH_STOPPED = 2'd3;

	// configuration register indexes
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 11;
	localparam logic [CfgIdxW-1:0] REG_COLOR_ZERO    = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_COLOR_ONE     = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_COLOR_TWO     = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_COLOR_THREE   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_TRANSPARENT   = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_SPACING       = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_TARGET_WIDTH  = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_TARGET_HEIGHT = 3'd7;

	// register reset values
	localparam logic [7:0]  RST_COLOR_ZERO    = 8'd0;
	localparam logic [7:0]  RST_COLOR_ONE     = 8'd15;
	localparam logic [7:0]  RST_COLOR_TWO     = 8'd7;
	localparam logic [7:0]  RST_COLOR_THREE   = 8'd8;
	localparam logic [7:0]  RST_TRANSPARENT   = 8'd0;
	localparam logic [4:0]  RST_SPACING       = 5'd0;
	localparam logic [10:0] RST_TARGET_WIDTH  = 11'd320;
	localparam logic [10:0] RST_TARGET_HEIGHT = 11'd200;

	// largest usable destination extent
	localparam logic [10:0] LIMIT_MAX = 11'd1024;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [9:0]         start_x;
		logic signed [10:0] start_y;
		logic [7:0]         font_height;
		logic [7:0]         glyph_cols;
		logic [7:0]         glyph_byte;
	} item_t;

	typedef struct packed {
		logic [9:0]         pixel_x;
		logic [9:0]         pixel_y;
		logic [7:0]         pixel_color;
		logic               write_enable;
		logic               char_done;
		logic               stopped;
		logic signed [11:0] end_x;
		logic               last;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic decode;
		logic emit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic has_results;
		logic slot_free;
		logic last_emit;
	} dp_stat_t;

endpackage

// ===== sv/glb2_if.sv =====
interface glb2_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [9:0]         start_x;
	logic signed [10:0] start_y;
	logic [7:0]         font_height;
	logic [7:0]         glyph_cols;
	logic [7:0]         glyph_byte;

	modport source (output valid, cmd, start_x, start_y, font_height, glyph_cols, glyph_byte,
		input ready);
	modport sink (input valid, cmd, start_x, start_y, font_height, glyph_cols, glyph_byte,
		output ready);
endinterface

interface glb2_result_if;
	logic               valid;
	logic               ready;
	logic [9:0]         pixel_x;
	logic [9:0]         pixel_y;
	logic [7:0]         pixel_color;
	logic               write_enable;
	logic               char_done;
	logic               stopped;
	logic signed [11:0] end_x;
	logic               last;

	modport source (output valid, pixel_x, pixel_y, pixel_color, write_enable, char_done,
		stopped, end_x, last, input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_color, write_enable, char_done,
		stopped, end_x, last, output ready);
endinterface

interface glb2_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [10:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/glb2_ctrl.sv =====
module glb2_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  glb2_pkg::dp_stat_t    stat,
	output glb2_pkg::ctrl_cmd_t   cmd
);

	localparam logic [1:0] ST_WAIT   = 2'd0;
	localparam logic [1:0] ST_DECODE = 2'd1;
	localparam logic [1:0] ST_EMIT   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		item_ready  = 1'b0;
		cmd.capture = 1'b0;
		cmd.decode  = 1'b0;
		cmd.emit    = 1'b0;
		unique case (state_q)
			ST_WAIT: begin
				item_ready  = 1'b1;
				cmd.capture = item_valid;
				if (item_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				state_d    = stat.has_results ? ST_EMIT : ST_WAIT;
			end
			ST_EMIT: begin
				cmd.emit = stat.slot_free;
				if (stat.slot_free && stat.last_emit) begin
					state_d = ST_WAIT;
				end
			end
			default: begin
				state_d = ST_WAIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WAIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/glb2_dp.sv =====
module glb2_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  glb2_pkg::ctrl_cmd_t                   cmd,
	output glb2_pkg::dp_stat_t                    stat,
	input  glb2_pkg::item_t                       item_in,
	input  logic                                  cfg_we,
	input  logic [glb2_pkg::CfgIdxW-1:0]          cfg_index,
	input  logic [glb2_pkg::CfgDataW-1:0]         cfg_data,
	input  logic                                  res_ready,
	output logic                                  res_valid,
	output glb2_pkg::result_t                     res
);

	// configuration registers
	logic [7:0]  color_zero_q, color_one_q, color_two_q, color_three_q, transp_q;
	logic [4:0]  spacing_q;
	logic [10:0] tgt_w_q, tgt_h_q;

	// string state
	logic [1:0]  phase_q;
	logic [11:0] pen_q;
	logic [10:0] stop_q;
	logic [7:0]  skip_rows_q;
	logic [7:0]  vis_rows_q;
	logic [9:0]  row_y_q;
	logic [7:0]  gw_q;
	logic [13:0] bskip_q;
	logic [7:0]  row_q;
	logic [7:0]  col_q;

	// captured request and emit sequencer
	glb2_pkg::item_t item_q;
	logic               em_status_q;
	logic [2:0]         em_left_q;
	logic signed [12:0] em_x_q;
	logic [9:0]         em_y_q;
	logic [7:0]         em_codes_q;
	logic               em_done_q;

	// result register
	glb2_pkg::result_t res_q;
	logic              res_valid_q;

	// clamped limits
	logic [10:0] lim_w, lim_h;
	assign lim_w = (tgt_w_q > glb2_pkg::LIMIT_MAX) ? glb2_pkg::LIMIT_MAX : tgt_w_q;
	assign lim_h = (tgt_h_q > glb2_pkg::LIMIT_MAX) ? glb2_pkg::LIMIT_MAX : tgt_h_q;

	// begin string: top and bottom clipping
	logic               y_neg;
	logic [10:0]        skip;
	logic [9:0]         y0;
	logic signed [11:0] rows_a, avail, rows;
	logic               str_stop;
	assign y_neg    = item_q.start_y[10];
	assign skip     = y_neg ? (~item_q.start_y + 11'd1) : 11'd0;
	assign y0       = y_neg ? 10'd0 : item_q.start_y[9:0];
	assign rows_a   = $signed({4'b0, item_q.font_height}) - $signed({1'b0, skip});
	assign avail    = $signed({1'b0, lim_h}) - $signed({2'b0, y0});
	assign str_stop = (rows_a <= 12'sd0) || (avail <= 12'sd0);
	assign rows     = (rows_a < avail) ? rows_a : avail;

	// begin character: right stop test and top skip byte count
	logic [1:0]         ph_in;
	logic signed [12:0] pen_right;
	logic               overrun;
	logic [8:0]         stride_sum;
	logic [14:0]        skip_prod;
	assign ph_in      = (phase_q == glb2_pkg::PH_GLYPH) ? glb2_pkg::PH_ACTIVE : phase_q;
	assign pen_right  = $signed({pen_q[11], pen_q}) + $signed({5'b0, item_q.glyph_cols});
	assign overrun    = pen_right >= $signed({2'b0, stop_q});
	assign stride_sum = {1'b0, item_q.glyph_cols} + 9'd3;
	assign skip_prod  = 15'(skip_rows_q) * 15'(stride_sum[8:2]);

	// glyph byte: pixels in this byte and row/column advance
	logic [7:0]  rem;
	logic [2:0]  npix;
	logic [8:0]  col_sum;
	logic        row_end;
	logic [8:0]  row_inc;
	logic        glyph_done;
	logic [11:0] pen_adv;
	assign rem        = gw_q - col_q;
	assign npix       = (rem > 8'd4) ? 3'd4 : rem[2:0];
	assign col_sum    = {1'b0, col_q} + {6'b0, npix};
	assign row_end    = col_sum >= {1'b0, gw_q};
	assign row_inc    = {1'b0, row_q} + 9'd1;
	assign glyph_done = row_end && (row_inc >= {1'b0, vis_rows_q});
	assign pen_adv    = pen_q + {4'b0, gw_q} + {{7{spacing_q[4]}}, spacing_q};

	logic is_string, is_char, is_draw_byte;
	assign is_string    = item_q.cmd == glb2_pkg::CMD_STRING;
	assign is_char      = item_q.cmd == glb2_pkg::CMD_CHAR;
	assign is_draw_byte = (item_q.cmd == glb2_pkg::CMD_BYTE) &&
		(phase_q == glb2_pkg::PH_GLYPH);

	assign stat.has_results = is_string || is_char || (is_draw_byte && (bskip_q == 14'd0));
	assign stat.slot_free   = !res_valid_q || res_ready;
	assign stat.last_emit   = em_left_q == 3'd1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_zero_q  <= glb2_pkg::RST_COLOR_ZERO;
			color_one_q   <= glb2_pkg::RST_COLOR_ONE;
			color_two_q   <= glb2_pkg::RST_COLOR_TWO;
			color_three_q <= glb2_pkg::RST_COLOR_THREE;
			transp_q      <= glb2_pkg::RST_TRANSPARENT;
			spacing_q     <= glb2_pkg::RST_SPACING;
			tgt_w_q       <= glb2_pkg::RST_TARGET_WIDTH;
			tgt_h_q       <= glb2_pkg::RST_TARGET_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				glb2_pkg::REG_COLOR_ZERO:    color_zero_q  <= cfg_data[7:0];
				glb2_pkg::REG_COLOR_ONE:     color_one_q   <= cfg_data[7:0];
				glb2_pkg::REG_COLOR_TWO:     color_two_q   <= cfg_data[7:0];
				glb2_pkg::REG_COLOR_THREE:   color_three_q <= cfg_data[7:0];
				glb2_pkg::REG_TRANSPARENT:   transp_q      <= cfg_data[7:0];
				glb2_pkg::REG_SPACING:       spacing_q     <= cfg_data[4:0];
				glb2_pkg::REG_TARGET_WIDTH:  tgt_w_q       <= cfg_data;
				glb2_pkg::REG_TARGET_HEIGHT: tgt_h_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item_in;
		end
	end

	// string state update on decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= glb2_pkg::PH_IDLE;
			pen_q       <= '0;
			stop_q      <= '0;
			skip_rows_q <= '0;
			vis_rows_q  <= '0;
			row_y_q     <= '0;
			gw_q        <= '0;
			bskip_q     <= '0;
			row_q       <= '0;
			col_q       <= '0;
		end else if (cmd.decode) begin
			priority if (is_string) begin
				stop_q  <= lim_w;
				col_q   <= '0;
				row_q   <= '0;
				bskip_q <= '0;
				gw_q    <= '0;
				if (str_stop) begin
					phase_q     <= glb2_pkg::PH_STOPPED;
					pen_q       <= '0;
					skip_rows_q <= '0;
					vis_rows_q  <= '0;
					row_y_q     <= '0;
				end else begin
					phase_q     <= glb2_pkg::PH_ACTIVE;
					pen_q       <= {2'b0, item_q.start_x};
					skip_rows_q <= skip[7:0];
					vis_rows_q  <= rows[7:0];
					row_y_q     <= y0;
				end
			end else if (is_char) begin
				phase_q <= ph_in;
				if ((ph_in == glb2_pkg::PH_ACTIVE) && (item_q.glyph_cols != 8'd0)) begin
					if (overrun) begin
						phase_q <= glb2_pkg::PH_STOPPED;
					end else begin
						phase_q <= glb2_pkg::PH_GLYPH;
						gw_q    <= item_q.glyph_cols;
						bskip_q <= skip_prod[13:0];
						row_q   <= '0;
						col_q   <= '0;
					end
				end
			end else if (is_draw_byte) begin
				if (bskip_q != 14'd0) begin
					bskip_q <= bskip_q - 14'd1;
				end else begin
					col_q <= row_end ? 8'd0 : col_sum[7:0];
					if (row_end) begin
						row_q <= row_inc[7:0];
					end
					if (glyph_done) begin
						phase_q <= glb2_pkg::PH_ACTIVE;
						pen_q   <= pen_adv;
					end
				end
			end else begin
			end
		end
	end

	// emit sequencer: status or one pixel per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_left_q <= '0;
		end else if (cmd.decode) begin
			em_left_q <= is_draw_byte ? npix : 3'd1;
		end else if (cmd.emit) begin
			em_left_q <= em_left_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			em_status_q <= !is_draw_byte;
			em_x_q      <= $signed({pen_q[11], pen_q}) + $signed({5'b0, col_q});
			em_y_q      <= row_y_q + {2'b0, row_q};
			em_codes_q  <= item_q.glyph_byte;
			em_done_q   <= glyph_done;
		end else if (cmd.emit) begin
			em_x_q     <= em_x_q + 13'sd1;
			em_codes_q <= {em_codes_q[5:0], 2'b00};
		end
	end

	// palette lookup for the current code
	logic [7:0] pix_color;
	always_comb begin
		unique case (em_codes_q[7:6])
			2'd0:    pix_color = color_zero_q;
			2'd1:    pix_color = color_one_q;
			2'd2:    pix_color = color_two_q;
			default: pix_color = color_three_q;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.end_x <= $signed(pen_q);
			res_q.last  <= em_left_q == 3'd1;
			if (em_status_q) begin
				res_q.pixel_x      <= '0;
				res_q.pixel_y      <= '0;
				res_q.pixel_color  <= '0;
				res_q.write_enable <= 1'b0;
				res_q.char_done    <= 1'b0;
				res_q.stopped      <= phase_q == glb2_pkg::PH_STOPPED;
			end else begin
				res_q.pixel_x      <= em_x_q[12] ? 10'd0 : em_x_q[9:0];
				res_q.pixel_y      <= em_y_q;
				res_q.pixel_color  <= pix_color;
				res_q.write_enable <= (pix_color != transp_q) && !em_x_q[12];
				res_q.char_done    <= em_done_q && (em_left_q == 3'd1);
				res_q.stopped      <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== sv/glyph_blitter_2bpp_clipped.sv =====
// Text blitter for 2-bit-per-pixel fonts with top, bottom and right clipping.
// Requests on item are begin-string, begin-character and packed glyph bytes;
// each begin request returns one status result, each visible glyph byte returns
// one pixel result per code inside the glyph width (1 to 4), and top-clipped
// bytes return nothing. One request is handled at a time: an accepted request
// is decoded, then its results are loaded into the single result register,
// one result per cycle while the result port does not stall; a top-clipped or
// dropped byte goes from decode straight back to waiting. Configuration writes
// are taken in any cycle (cfg.ready is always high) but must only be issued
// while idle.
module glyph_blitter_2bpp_clipped (
	input logic           clk,
	input logic           arst_n,
	glb2_item_if.sink     item,
	glb2_result_if.source result,
	glb2_cfg_if.sink      cfg
);

	glb2_pkg::ctrl_cmd_t ctrl_cmd;
	glb2_pkg::dp_stat_t  dp_stat;
	glb2_pkg::item_t     item_bus;
	glb2_pkg::result_t   res_bus;
	logic                item_rdy;
	logic                res_vld;

	assign item_bus.cmd         = item.cmd;
	assign item_bus.start_x     = item.start_x;
	assign item_bus.start_y     = item.start_y;
	assign item_bus.font_height = item.font_height;
	assign item_bus.glyph_cols  = item.glyph_cols;
	assign item_bus.glyph_byte  = item.glyph_byte;

	assign item.ready = item_rdy;
	assign cfg.ready  = 1'b1;

	glb2_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_rdy),
		.stat       (dp_stat),
		.cmd        (ctrl_cmd)
	);

	glb2_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (ctrl_cmd),
		.stat      (dp_stat),
		.item_in   (item_bus),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.res_ready (result.ready),
		.res_valid (res_vld),
		.res       (res_bus)
	);

	// result port
	assign result.valid        = res_vld;
	assign result.pixel_x      = res_bus.pixel_x;
	assign result.pixel_y      = res_bus.pixel_y;
	assign result.pixel_color  = res_bus.pixel_color;
	assign result.write_enable = res_bus.write_enable;
	assign result.char_done    = res_bus.char_done;
	assign result.stopped      = res_bus.stopped;
	assign result.end_x        = res_bus.end_x;
	assign result.last         = res_bus.last;

	// an accepted request is always decoded before the next is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("request accepted while previous still in decode");

	// a stopped status is never a pixel write and always closes its request
	a_stopped_status: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.stopped) |-> (!result.write_enable && result.last))
		else $error("stopped flag on a pixel result");

	// glyph completion only on the final pixel of a byte
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.char_done) |-> result.last)
		else $error("char_done before the last pixel of the byte");

	// nothing is emitted while a request waits for decode
	a_no_emit_in_decode: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.decode |-> !ctrl_cmd.emit && !ctrl_cmd.capture)
		else $error("emit or capture during decode");

endmodule
